[rtl/core/ectc_pkg.sv]
`default_nettype none
package ectc_pkg;

  localparam int FieldBits = 16;
  localparam int TraceBits = 11;
  localparam int OrderBits = 17;
  localparam int SumBits = FieldBits + 2;

  localparam logic [FieldBits-1:0] PrimeReset = FieldBits'(587);
  localparam logic [TraceBits-1:0] TraceMax = {1'b0, {(TraceBits-1){1'b1}}};
  localparam logic [TraceBits-1:0] TraceMin = {1'b1, {(TraceBits-1){1'b0}}};

  // register index of field_prime
  localparam logic [0:0] RegFieldPrime = 1'b0;

  // datapath micro operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED_A,
    OP_RED_B,
    OP_MUL,
    OP_DISC,
    OP_X_INIT,
    OP_RHS,
    OP_POW_INIT,
    OP_POW_MUL,
    OP_POW_SQR,
    OP_ACCUM,
    OP_X_NEXT
  } op_t;

  // reducer operand selects
  typedef enum logic [3:0] {
    MS_AA,
    MS_AAA,
    MS_BB,
    MS_XX,
    MS_XXX,
    MS_AX,
    MS_ACC_BASE,
    MS_BASE_BASE,
    MS_A,
    MS_B,
    MS_DISC,
    MS_RHS
  } msel_t;

  // temporary register selects
  typedef enum logic [1:0] {
    DST_T0,
    DST_T1,
    DST_T2
  } dst_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
    logic  mod_start;
    dst_t  dst;
    logic  clear;
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic p_small;
    logic disc_zero;
    logic x_last;
    logic e_zero;
  } stat_t;

endpackage
`default_nettype wire

[rtl/core/ectc_mod.sv]
`default_nettype none
// restoring reduction of a 34 bit value by a 16 bit modulus, one bit a cycle
module ectc_mod (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic [2*ectc_pkg::FieldBits+1:0] num,
  input  wire logic [ectc_pkg::FieldBits-1:0] modulus,
  output logic done,
  output logic [ectc_pkg::FieldBits-1:0] rem
);
  localparam int NB = 2 * ectc_pkg::FieldBits + 2;
  localparam int RB = ectc_pkg::FieldBits + 1;

  logic [NB-1:0] num_r, num_nxt;
  logic [RB-1:0] rem_r, rem_nxt;
  logic [$clog2(NB+1)-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [RB:0] trial;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r, num_r[NB-1]} - {2'b00, modulus};
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      cnt_nxt = ($clog2(NB+1))'(NB);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[NB-2:0], 1'b0};
      if (!trial[RB]) begin
        rem_nxt = trial[RB-1:0];
      end else begin
        rem_nxt = {rem_r[RB-2:0], num_r[NB-1]};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ($clog2(NB+1))'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done = busy_r && (cnt_r == ($clog2(NB+1))'(1));
  assign rem = trial[RB] ? {rem_r[RB-3:0], num_r[NB-1]} : trial[RB-2:0];
endmodule
`default_nettype wire

[rtl/core/ectc_dp.sv]
`default_nettype none
module ectc_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire ectc_pkg::cmd_t cmd,
  input  wire logic [ectc_pkg::FieldBits-1:0] prime,
  input  wire logic [ectc_pkg::FieldBits-1:0] coef_a,
  input  wire logic [ectc_pkg::FieldBits-1:0] coef_b,
  output ectc_pkg::stat_t stat,
  output logic nonsingular,
  output logic signed [ectc_pkg::TraceBits-1:0] frobenius_trace,
  output logic [ectc_pkg::OrderBits-1:0] curve_order
);
  localparam int FB = ectc_pkg::FieldBits;
  localparam int NB = 2 * FB + 2;
  localparam int SB = ectc_pkg::SumBits;

  logic [FB-1:0] p_r, a_r, b_r, x_r, t0_r, t1_r, t2_r, base_r, acc_r, e_r;
  logic [FB-1:0] a_nxt, b_nxt, x_nxt, t0_nxt, t1_nxt, t2_nxt, base_nxt, acc_nxt, e_nxt;
  logic signed [SB-1:0] sum_r, sum_nxt;
  logic [FB-1:0] op_l, op_r;
  logic [2*FB-1:0] prod;
  logic [NB-1:0] num;
  logic [FB-1:0] rem;
  logic mdone;
  logic [FB+2:0] acc3;
  logic signed [SB-1:0] tr;
  logic signed [FB+2:0] ord;

  always_comb begin
    op_l = '0;
    op_r = '0;
    case (cmd.msel)
      ectc_pkg::MS_AA: begin op_l = a_r; op_r = a_r; end
      ectc_pkg::MS_AAA: begin op_l = t0_r; op_r = a_r; end
      ectc_pkg::MS_BB: begin op_l = b_r; op_r = b_r; end
      ectc_pkg::MS_XX: begin op_l = x_r; op_r = x_r; end
      ectc_pkg::MS_XXX: begin op_l = t0_r; op_r = x_r; end
      ectc_pkg::MS_AX: begin op_l = a_r; op_r = x_r; end
      ectc_pkg::MS_ACC_BASE: begin op_l = acc_r; op_r = base_r; end
      ectc_pkg::MS_BASE_BASE: begin op_l = base_r; op_r = base_r; end
      default: ;
    endcase
    prod = (2*FB)'(op_l) * (2*FB)'(op_r);
    acc3 = (FB+3)'(t1_r) + (FB+3)'(t2_r) + (FB+3)'(b_r);
    case (cmd.msel)
      ectc_pkg::MS_A: num = NB'(a_r);
      ectc_pkg::MS_B: num = NB'(b_r);
      ectc_pkg::MS_DISC: num = (NB'(t1_r) << 2) + NB'(t2_r) * NB'(27);
      ectc_pkg::MS_RHS: num = NB'(acc3);
      default: num = NB'(prod);
    endcase
  end

  ectc_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(cmd.mod_start), .num(num),
    .modulus(p_r), .done(mdone), .rem(rem)
  );

  always_comb begin
    a_nxt = a_r; b_nxt = b_r; x_nxt = x_r; t0_nxt = t0_r; t1_nxt = t1_r;
    t2_nxt = t2_r; base_nxt = base_r; acc_nxt = acc_r; e_nxt = e_r; sum_nxt = sum_r;
    unique case (cmd.op) inside
      ectc_pkg::OP_LOAD: begin
        a_nxt = coef_a; b_nxt = coef_b; sum_nxt = '0;
      end
      ectc_pkg::OP_RED_A: a_nxt = rem;
      ectc_pkg::OP_RED_B: b_nxt = rem;
      ectc_pkg::OP_MUL, ectc_pkg::OP_DISC, ectc_pkg::OP_RHS: begin
        case (cmd.dst)
          ectc_pkg::DST_T0: t0_nxt = rem;
          ectc_pkg::DST_T1: t1_nxt = rem;
          default: t2_nxt = rem;
        endcase
      end
      ectc_pkg::OP_X_INIT: x_nxt = '0;
      ectc_pkg::OP_POW_INIT: begin
        base_nxt = t0_r; acc_nxt = FB'(1); e_nxt = (p_r - FB'(1)) >> 1;
      end
      ectc_pkg::OP_POW_MUL: begin
        // multiply in only for a set exponent bit
        if (e_r[0]) begin
          acc_nxt = rem;
        end
      end
      ectc_pkg::OP_POW_SQR: begin
        base_nxt = rem;
        e_nxt = e_r >> 1;
      end
      ectc_pkg::OP_ACCUM: begin
        if (t0_r != '0) begin
          sum_nxt = (acc_r == FB'(1)) ? sum_r + SB'(1) : sum_r - SB'(1);
        end
      end
      ectc_pkg::OP_X_NEXT: x_nxt = x_r + FB'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonsingular <= 1'b0;
      frobenius_trace <= '0;
      curve_order <= '0;
    end else if (cmd.clear) begin
      nonsingular <= 1'b0;
      frobenius_trace <= '0;
      curve_order <= '0;
    end else if (cmd.op == ectc_pkg::OP_X_NEXT && stat.x_last) begin
      nonsingular <= 1'b1;
      frobenius_trace <= tr[ectc_pkg::TraceBits-1:0];
      curve_order <= ord[ectc_pkg::OrderBits-1:0];
    end
    if (cmd.op == ectc_pkg::OP_LOAD) p_r <= prime;
    a_r <= a_nxt; b_r <= b_nxt; x_r <= x_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt;
    t2_r <= t2_nxt; base_r <= base_nxt; acc_r <= acc_nxt; e_r <= e_nxt; sum_r <= sum_nxt;
  end

  always_comb begin
    tr = -sum_nxt;
    if (tr > $signed(SB'(signed'(ectc_pkg::TraceMax)))) tr = SB'(signed'(ectc_pkg::TraceMax));
    if (tr < SB'(signed'(ectc_pkg::TraceMin))) tr = SB'(signed'(ectc_pkg::TraceMin));
    ord = $signed({3'b000, p_r}) + (FB+3)'(1) - (FB+3)'(tr);
  end

  assign stat.mod_done = mdone;
  assign stat.p_small = (prime < FB'(3));
  assign stat.disc_zero = (rem == '0);
  assign stat.x_last = (x_r == p_r - FB'(1));
  assign stat.e_zero = (e_r == '0);
endmodule
`default_nettype wire

[rtl/core/ectc_ctrl.sv]
`default_nettype none
module ectc_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire ectc_pkg::stat_t stat,
  output ectc_pkg::cmd_t cmd,
  output logic idle,
  output logic done_v
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RA   = 11'b00000000010,
    S_RB   = 11'b00000000100,
    S_AA   = 11'b00000001000,
    S_AAA  = 11'b00000010000,
    S_BB   = 11'b00000100000,
    S_DISC = 11'b00001000000,
    S_XX   = 11'b00010000000,
    S_XXX  = 11'b00100000000,
    S_POW  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  // sub step inside point loop and power loop
  logic [2:0] sub_r, sub_nxt;
  logic run_r, run_nxt;
  state_t st_r, st_nxt;
  logic m;

  always_comb begin
    st_nxt = st_r;
    sub_nxt = sub_r;
    run_nxt = run_r;
    cmd = '{op: ectc_pkg::OP_NONE, msel: ectc_pkg::MS_AA, mod_start: 1'b0,
            dst: ectc_pkg::DST_T0, clear: 1'b0};
    m = stat.mod_done;
    unique case (st_r) inside
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = ectc_pkg::OP_LOAD;
          cmd.clear = 1'b1;
          st_nxt = stat.p_small ? S_OUT : S_RA;
          run_nxt = 1'b0;
        end
      end
      // curve setup: one reduce step each
      S_RA, S_RB, S_AA, S_AAA, S_BB, S_DISC: begin
        unique case (st_r)
          S_RA: cmd.msel = ectc_pkg::MS_A;
          S_RB: cmd.msel = ectc_pkg::MS_B;
          S_AA: begin cmd.msel = ectc_pkg::MS_AA; cmd.dst = ectc_pkg::DST_T0; end
          S_AAA: begin cmd.msel = ectc_pkg::MS_AAA; cmd.dst = ectc_pkg::DST_T1; end
          S_BB: begin cmd.msel = ectc_pkg::MS_BB; cmd.dst = ectc_pkg::DST_T2; end
          default: begin cmd.msel = ectc_pkg::MS_DISC; cmd.dst = ectc_pkg::DST_T0; end
        endcase
        if (!run_r) begin
          cmd.mod_start = 1'b1;
          run_nxt = 1'b1;
        end else if (m) begin
          run_nxt = 1'b0;
          unique case (st_r)
            S_RA: begin cmd.op = ectc_pkg::OP_RED_A; st_nxt = S_RB; end
            S_RB: begin cmd.op = ectc_pkg::OP_RED_B; st_nxt = S_AA; end
            S_AA: begin cmd.op = ectc_pkg::OP_MUL; st_nxt = S_AAA; end
            S_AAA: begin cmd.op = ectc_pkg::OP_MUL; st_nxt = S_BB; end
            S_BB: begin cmd.op = ectc_pkg::OP_MUL; st_nxt = S_DISC; end
            default: begin
              cmd.op = ectc_pkg::OP_DISC;
              if (stat.disc_zero) begin
                st_nxt = S_OUT;
              end else begin
                st_nxt = S_XX;
                sub_nxt = 3'd0;
              end
            end
          endcase
        end
      end
      // point loop: x*x, x*x*x, a*x, rhs, then power
      S_XX: begin
        if (sub_r == 3'd0) begin
          cmd.op = ectc_pkg::OP_X_INIT;
          sub_nxt = 3'd1;
        end else begin
          unique case (sub_r)
            3'd1: begin cmd.msel = ectc_pkg::MS_XX; cmd.dst = ectc_pkg::DST_T0; end
            3'd2: begin cmd.msel = ectc_pkg::MS_XXX; cmd.dst = ectc_pkg::DST_T1; end
            3'd3: begin cmd.msel = ectc_pkg::MS_AX; cmd.dst = ectc_pkg::DST_T2; end
            default: begin cmd.msel = ectc_pkg::MS_RHS; cmd.dst = ectc_pkg::DST_T0; end
          endcase
          if (!run_r) begin
            cmd.mod_start = 1'b1;
            run_nxt = 1'b1;
          end else if (m) begin
            run_nxt = 1'b0;
            if (sub_r == 3'd4) begin
              cmd.op = ectc_pkg::OP_RHS;
              st_nxt = S_XXX;
            end else begin
              cmd.op = ectc_pkg::OP_MUL;
              sub_nxt = sub_r + 3'd1;
            end
          end
        end
      end
      S_XXX: begin
        cmd.op = ectc_pkg::OP_POW_INIT;
        st_nxt = S_POW;
        sub_nxt = 3'd0;
      end
      S_POW: begin
        if (sub_r == 3'd2) begin
          cmd.op = ectc_pkg::OP_X_NEXT;
          if (stat.x_last) begin
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_XX;
            sub_nxt = 3'd1;
          end
        end else if (sub_r == 3'd0 && !run_r && stat.e_zero) begin
          cmd.op = ectc_pkg::OP_ACCUM;
          sub_nxt = 3'd2;
        end else begin
          // sub 0: acc*base, kept for an odd exponent; sub 1: base*base
          if (sub_r == 3'd0) begin
            cmd.msel = ectc_pkg::MS_ACC_BASE;
          end else begin
            cmd.msel = ectc_pkg::MS_BASE_BASE;
          end
          if (!run_r) begin
            cmd.mod_start = 1'b1;
            run_nxt = 1'b1;
          end else if (m) begin
            run_nxt = 1'b0;
            if (sub_r == 3'd0) begin
              cmd.op = ectc_pkg::OP_POW_MUL;
              sub_nxt = 3'd1;
            end else begin
              cmd.op = ectc_pkg::OP_POW_SQR;
              sub_nxt = 3'd0;
            end
          end
        end
      end
      S_OUT: begin
        if (out_fire) st_nxt = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      sub_r <= '0;
      run_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sub_r <= sub_nxt;
      run_r <= run_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign done_v = (st_r == S_OUT);
endmodule
`default_nettype wire

[rtl/core/elliptic_curve_trace_count.sv]
`default_nettype none
// elliptic curve point count by legendre symbol sum
// input channel: in_coef_a, in_coef_b with in_valid / in_ready; one item in flight
// result channel: out_nonsingular, out_frobenius_trace, out_curve_order with
// out_valid / out_ready
// config: apb port, field_prime at address 0; write only while idle
// every modular step is one serial reduction: a start step, then a step per bit of 34
// setup: 6 reductions (a, b, a^2, a^3, b^2, discriminant)
// per x: 4 reductions for the cubic, 3 plain register steps, and 2 reductions per
// bit of (p-1)/2
// a singular curve ends after setup; p below three skips setup and the point loop
// throughput: one item at a time, the serial reducer sets the rate;
// in_ready rises at the edge that takes the result
// reset: field_prime returns to 587, no result pending
// a stalled receiver holds the result and keeps in_ready low
module elliptic_curve_trace_count (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [15:0] in_coef_a,
  input  wire logic [15:0] in_coef_b,
  output logic out_valid,
  input  wire logic out_ready,
  output logic out_nonsingular,
  output logic signed [10:0] out_frobenius_trace,
  output logic [16:0] out_curve_order,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [0:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [ectc_pkg::FieldBits-1:0] prime_r;
  ectc_pkg::cmd_t cmd;
  ectc_pkg::stat_t stat;
  logic idle, done_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= ectc_pkg::PrimeReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == ectc_pkg::RegFieldPrime) begin
      prime_r <= cfg_pwdata[ectc_pkg::FieldBits-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ectc_pkg::RegFieldPrime) ? 32'(prime_r) : '0;
  assign in_ready = idle;
  assign out_valid = done_v;

  ectc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && in_ready),
    .out_fire(out_valid && out_ready), .stat(stat), .cmd(cmd),
    .idle(idle), .done_v(done_v)
  );

  ectc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .prime(prime_r),
    .coef_a(in_coef_a), .coef_b(in_coef_b), .stat(stat),
    .nonsingular(out_nonsingular), .frobenius_trace(out_frobenius_trace),
    .curve_order(out_curve_order)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_nonsingular |-> out_curve_order == '0 && out_frobenius_trace == '0)
    else $error("singular result not zero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_curve_order))
    else $error("result dropped");
endmodule
`default_nettype wire
